// ===== rtl/core/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared widths, character codes, command codes and types of the text
// console cursor engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 8;

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_RESULT
    } t_state;

    // Decode of the pending put byte, cursor unit to screen sequencer
    typedef struct packed {
        logic printable;
        logic scroll;
    } t_put_info;

endpackage

// ===== rtl/core/tcce_if.sv =====
// ----------------------------------------------------------------------------
// tcce_if
// Valid/ready channels of the console: command beats in, result beats out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcce_cmd_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, cmd, char_code, cell_index, input ready);
    modport sink   (input valid, cmd, char_code, cell_index, output ready);
endinterface

interface tcce_res_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  cursor_index;
    logic [CELL_W-1:0] cell_data;

    modport source (output valid, cursor_index, cell_data, input ready);
    modport sink   (input valid, cursor_index, cell_data, output ready);
endinterface

// ===== rtl/core/tcce_cursor.sv =====
// ----------------------------------------------------------------------------
// tcce_cursor
// Cursor column/row registers, put-byte decode, wrap and scroll detection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_cursor #(
    parameter  int COLUMNS   = tcce_pkg::COLUMNS_DEF,
    parameter  int ROWS      = tcce_pkg::ROWS_DEF,
    parameter  int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(COLUMNS * ROWS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_home,
    input  logic [tcce_pkg::CHAR_W-1:0] i_char_code,
    output tcce_pkg::t_put_info         o_put,
    output logic [ADDR_W-1:0]           o_cell_addr,
    output logic [tcce_pkg::IDX_W-1:0]  o_cursor_index
);
    import tcce_pkg::*;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int PH_W   = $clog2(TAB_WIDTH);
    localparam int COLX_W = $clog2(COLUMNS + TAB_WIDTH);
    localparam int ROWX_W = $clog2(ROWS + 1);

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PH_W-1:0]   r_phase;   // column modulo tab width, kept alongside
    logic [COLX_W-1:0] n_col;
    logic [ROWX_W-1:0] n_row;
    logic [PH_W-1:0]   n_phase;
    logic              w_printable;
    logic              w_scroll;
    logic [ADDR_W-1:0] w_lin;

    always_comb begin
        w_printable = (i_char_code >= CH_SPACE) && (i_char_code <= CH_DEL);
        n_col       = COLX_W'(r_col);
        n_row       = ROWX_W'(r_row);
        n_phase     = r_phase;
        case (i_char_code)
            CH_BS: begin
                if (r_col != '0) begin
                    n_col   = COLX_W'(r_col) - COLX_W'(1);
                    n_phase = (r_phase == '0) ? PH_W'(TAB_WIDTH - 1) : r_phase - PH_W'(1);
                end
            end
            CH_TAB: begin
                n_col   = COLX_W'(r_col) + COLX_W'(TAB_WIDTH) - COLX_W'(r_phase);
                n_phase = '0;
            end
            CH_CR: begin
                n_col   = '0;
                n_phase = '0;
            end
            CH_LF: begin
                n_col   = '0;
                n_row   = ROWX_W'(r_row) + ROWX_W'(1);
                n_phase = '0;
            end
            default: begin
                if (w_printable) begin
                    n_col   = COLX_W'(r_col) + COLX_W'(1);
                    n_phase = (r_phase == PH_W'(TAB_WIDTH - 1)) ? '0 : r_phase + PH_W'(1);
                end
            end
        endcase
        // wrap to the next line
        if (n_col >= COLX_W'(COLUMNS)) begin
            n_col   = '0;
            n_row   = ROWX_W'(r_row) + ROWX_W'(1);
            n_phase = '0;
        end
        w_scroll = (n_row >= ROWX_W'(ROWS));
        if (w_scroll) begin
            n_row = ROWX_W'(ROWS - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (i_home) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (i_step) begin
            r_col   <= COL_W'(n_col);
            r_row   <= ROW_W'(n_row);
            r_phase <= n_phase;
        end
    end

    assign w_lin          = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign o_cell_addr    = w_lin;
    assign o_cursor_index = IDX_W'(w_lin);
    assign o_put          = '{printable: w_printable, scroll: w_scroll};

endmodule

// ===== rtl/core/tcce_screen.sv =====
// ----------------------------------------------------------------------------
// tcce_screen
// Screen cell memory with its command sequencer: character writes, cell
// reads, scroll copy, blank fills and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_screen #(
    parameter  int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter  int ROWS    = tcce_pkg::ROWS_DEF,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int ADDR_W  = $clog2(CELLS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tcce_pkg::CMD_W-1:0]  i_cmd,
    input  logic [tcce_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tcce_pkg::IDX_W-1:0]  i_cell_index,
    input  logic [tcce_pkg::ATTR_W-1:0] i_attr,
    input  tcce_pkg::t_put_info         i_put,
    input  logic [ADDR_W-1:0]           i_cell_addr,
    input  logic [tcce_pkg::IDX_W-1:0]  i_cursor_index,
    output logic                        o_step,
    output logic                        o_home,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tcce_pkg::IDX_W-1:0]  o_cursor_index,
    output logic [tcce_pkg::CELL_W-1:0] o_cell_data
);
    import tcce_pkg::*;

    localparam int COPY_CNT = (ROWS - 1) * COLUMNS;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic              r_sw_wen, n_sw_wen;
    logic              r_sw_use_q, n_sw_use_q;
    logic [ADDR_W-1:0] r_sw_addr, n_sw_addr;
    logic [CELL_W-1:0] r_sw_fill, n_sw_fill;
    logic              r_rd_ok, n_rd_ok;
    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_out_cursor, n_out_cursor;
    logic [CELL_W-1:0] r_out_data, n_out_data;

    logic              w_accept;
    logic              w_slot_free;
    logic              w_in_range;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_wen;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic [CELL_W-1:0] w_blank;

    // hold off new commands until a trailing sweep write has landed
    assign o_ready     = (r_state == ST_IDLE) && !r_sw_wen;
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;
    assign w_in_range  = int'(i_cell_index) < CELLS;
    assign w_blank     = {i_attr, CH_SPACE};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        CMD_PUT:   n_state = i_put.scroll ? ST_COPY : ST_RESULT;
                        CMD_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_RESULT;
                    endcase
                end
            end
            ST_COPY: begin
                if (r_cnt == ADDR_W'(COPY_CNT - 1)) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL, ST_CLEAR: begin
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_step       = w_accept && (i_cmd == CMD_PUT);
        o_home       = w_accept && (i_cmd == CMD_CLEAR);
        w_rd_en      = 1'b0;
        w_rd_addr    = ADDR_W'(i_cell_index);
        n_cnt        = r_cnt;
        n_sw_wen     = 1'b0;
        n_sw_use_q   = 1'b0;
        n_sw_addr    = r_cnt;
        n_sw_fill    = w_blank;
        n_rd_ok      = r_rd_ok;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_cursor = r_out_cursor;
        n_out_data   = r_out_data;
        case (r_state)
            ST_INIT: begin
                n_sw_wen  = 1'b1;
                n_sw_fill = {ATTR_RESET, CH_SPACE};
                n_cnt     = r_cnt + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_cnt   = '0;
                    n_rd_ok = (i_cmd == CMD_READ) && w_in_range;
                    w_rd_en = (i_cmd == CMD_READ) && w_in_range;
                end
            end
            ST_COPY: begin
                // read one row down, write the registered cell back one row up
                w_rd_en    = 1'b1;
                w_rd_addr  = r_cnt + ADDR_W'(COLUMNS);
                n_sw_wen   = 1'b1;
                n_sw_use_q = 1'b1;
                n_cnt      = r_cnt + ADDR_W'(1);
            end
            ST_FILL, ST_CLEAR: begin
                n_sw_wen = 1'b1;
                n_cnt    = r_cnt + ADDR_W'(1);
            end
            ST_RESULT: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_cursor = i_cursor_index;
                    n_out_data   = r_rd_ok ? r_rd_data : '0;
                end
            end
            default: ;
        endcase
    end

    assign w_wen   = r_sw_wen || (o_step && i_put.printable);
    assign w_waddr = r_sw_wen ? r_sw_addr : i_cell_addr;
    assign w_wdata = r_sw_wen ? (r_sw_use_q ? r_rd_data : r_sw_fill) : {i_attr, i_char_code};

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_sw_wen    <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sw_wen    <= n_sw_wen;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_use_q   <= n_sw_use_q;
        r_sw_addr    <= n_sw_addr;
        r_sw_fill    <= n_sw_fill;
        r_out_cursor <= n_out_cursor;
        r_out_data   <= n_out_data;
    end

    assign o_valid        = r_out_valid;
    assign o_cursor_index = r_out_cursor;
    assign o_cell_data    = r_out_data;

endmodule

// ===== rtl/core/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text console: COLUMNS x ROWS screen of attribute/character cells with a
// cursor. Command beats arrive on i_cmd (put character, clear, read cell);
// each one returns exactly one result beat on o_res with the linear cursor
// index row*COLUMNS+col and, for an in-range read, the cell (zero otherwise).
// i_cfg_wr_en/i_cfg_wr_data load the text attribute; write it while idle.
// Result: a taken command moves the sequencer to its result state, through
// the sweep first for a scroll or a clear; there the result beat is loaded
// into the output register once that register is free. i_cmd.ready stays
// low from a taken command until its result is loaded, so commands are
// taken one at a time. A put that scrolls first copies the rows up through
// the one read port, then blanks the last row; a clear writes blank cells
// over the whole screen. Both sweeps go one cell per cycle.
// Reset: synchronous, active low. After reset the block fills the memory
// with blank cells, with i_cmd.ready low; configuration writes are taken
// meanwhile.
// Stall: a result waits in the output register while o_res.ready is low;
// the next command is still taken, and its result waits for the slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_engine #(
    parameter int COLUMNS   = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcce_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcce_cmd_if.sink                    i_cmd,
    tcce_res_if.source                  o_res,
    input  logic                        i_cfg_wr_en,
    input  logic [tcce_pkg::ATTR_W-1:0] i_cfg_wr_data
);
    import tcce_pkg::*;

    localparam int ADDR_W = $clog2(COLUMNS * ROWS);

    logic [ATTR_W-1:0] r_attr;
    t_put_info         w_put;
    logic [ADDR_W-1:0] w_cell_addr;
    logic [IDX_W-1:0]  w_cursor_index;
    logic              w_step;
    logic              w_home;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    tcce_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_cursor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_home         (w_home),
        .i_char_code    (i_cmd.char_code),
        .o_put          (w_put),
        .o_cell_addr    (w_cell_addr),
        .o_cursor_index (w_cursor_index)
    );

    tcce_screen #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_screen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_cmd.valid),
        .o_ready        (i_cmd.ready),
        .i_cmd          (i_cmd.cmd),
        .i_char_code    (i_cmd.char_code),
        .i_cell_index   (i_cmd.cell_index),
        .i_attr         (r_attr),
        .i_put          (w_put),
        .i_cell_addr    (w_cell_addr),
        .i_cursor_index (w_cursor_index),
        .o_step         (w_step),
        .o_home         (w_home),
        .o_valid        (o_res.valid),
        .i_ready        (o_res.ready),
        .o_cursor_index (o_res.cursor_index),
        .o_cell_data    (o_res.cell_data)
    );

endmodule

// ===== rtl/core/tcce_checker.sv =====
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the text console, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_checker #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [tcce_pkg::IDX_W-1:0]  i_cursor_index,
    input logic [tcce_pkg::CELL_W-1:0] i_cell_data
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    // one command at a time: ready drops right after a beat is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken on two consecutive cycles");

    // reset empties the result slot and starts the blanking pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("channels active right after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_cursor_index) && $stable(i_cell_data))
        else $error("stalled result beat changed");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> int'(i_cursor_index) < CELLS)
        else $error("cursor index beyond the screen");

endmodule

bind text_console_cursor_engine tcce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcce_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_cursor_index (o_res.cursor_index),
    .i_cell_data    (o_res.cell_data)
);

// ===== verif/tb_text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine
// Self-checking bench for the text console. Command beats go in through a
// valid/ready source with random gaps; result beats are taken by a sink with
// random stalls and one long hold-off. A shadow screen, cursor and attribute
// predict every result after a short table of directed commands with
// expected results; then the run goes through phases of text lines, reads,
// line-feed bursts, clears and noise, each under a newly loaded attribute.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
    import tcce_pkg::*;

    localparam int unsigned COLS  = COLUMNS_DEF;
    localparam int unsigned ROWS  = ROWS_DEF;
    localparam int unsigned TABW  = TAB_WIDTH_DEF;
    localparam int unsigned CELLS = COLS * ROWS;

    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [CHAR_W-1:0] CH_VT      = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_US      = 8'h1F;

    localparam int unsigned RESET_CYCLES    = 4;
    localparam int unsigned MAX_GAP         = 4;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned TAIL_CYCLES     = 40;
    localparam int unsigned PHASES          = 5;
    localparam int unsigned ITEMS_PER_PHASE = 245;
    localparam int unsigned ITEMS_TOTAL     = 24 + PHASES * ITEMS_PER_PHASE;
    // Worst case: every beat scrolls, both sides idle their longest
    localparam int unsigned RUN_LIMIT = 3 * (CELLS + 1 + HOLD_OFF_CYCLES
        + 2 * ITEMS_TOTAL * (CELLS + 2 + 2 * MAX_GAP + 4)
        + 4 * PHASES * SETTLE_CYCLES + TAIL_CYCLES);

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } console_cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_index;
        logic [CELL_W-1:0] cell_data;
    } console_report_t;

    typedef struct packed {
        console_cmd_t    c;
        logic            typed;
        console_report_t want;
    } directed_row_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [ATTR_W-1:0] i_cfg_wr_data;

    tcce_cmd_if cmd_ch ();
    tcce_res_if res_ch ();

    text_console_cursor_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_ch),
        .o_res         (res_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the console
    logic [CELL_W-1:0] shadow_cells [CELLS];
    int unsigned       shadow_col;
    int unsigned       shadow_row;
    logic [ATTR_W-1:0] shadow_attr;

    console_report_t reports_due [$];
    directed_row_t   directed_rows [$];

    int unsigned mismatches     = 0;
    int unsigned commands_sent  = 0;
    int unsigned reports_seen   = 0;
    int unsigned scrolls_seen   = 0;
    int unsigned clears_seen    = 0;
    int unsigned attrs_loaded   = 0;
    int unsigned cycle_count    = 0;
    bit          hold_off_req   = 1'b0;
    bit          sender_gapless = 1'b0;
    bit          sink_gapless   = 1'b0;

    function automatic void blank_cells(int unsigned first, int unsigned count);
        for (int unsigned k = first; k < first + count && k < CELLS; k++)
            shadow_cells[k] = {shadow_attr, CH_SPACE};
    endfunction

    function automatic console_report_t advance_console(console_cmd_t c);
        console_report_t r;
        r.cell_data = '0;
        case (c.cmd)
            CMD_PUT: begin
                if (c.char_code == CH_BS) begin
                    if (shadow_col != 0)
                        shadow_col--;
                end else if (c.char_code == CH_TAB) begin
                    shadow_col = (shadow_col / TABW + 1) * TABW;
                end else if (c.char_code == CH_CR) begin
                    shadow_col = 0;
                end else if (c.char_code == CH_LF) begin
                    shadow_col = 0;
                    shadow_row++;
                end else if (c.char_code >= CH_SPACE && c.char_code <= CH_DEL) begin
                    shadow_cells[shadow_row * COLS + shadow_col] = {shadow_attr, c.char_code};
                    shadow_col++;
                end
                if (shadow_col >= COLS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // Scroll up one line and blank the bottom row
                if (shadow_row >= ROWS) begin
                    for (int unsigned k = 0; k < CELLS - COLS; k++)
                        shadow_cells[k] = shadow_cells[k + COLS];
                    blank_cells(CELLS - COLS, COLS);
                    shadow_row = ROWS - 1;
                    scrolls_seen++;
                end
            end
            CMD_CLEAR: begin
                blank_cells(0, CELLS);
                shadow_col = 0;
                shadow_row = 0;
                clears_seen++;
            end
            CMD_READ: begin
                if (c.cell_index < CELLS)
                    r.cell_data = shadow_cells[c.cell_index];
            end
            default: ;
        endcase
        r.cursor_index = IDX_W'(shadow_row * COLS + shadow_col);
        return r;
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx, input logic typed,
                           input int unsigned cur, input logic [CELL_W-1:0] data);
        directed_row_t r;
        r.c.cmd               = cmd;
        r.c.char_code         = ch;
        r.c.cell_index        = idx;
        r.typed               = typed;
        r.want.cursor_index   = IDX_W'(cur);
        r.want.cell_data      = data;
        directed_rows.push_back(r);
    endtask

    task automatic send_cmd(input console_cmd_t c, input logic typed,
                            input console_report_t want);
        int unsigned     gap;
        console_report_t predicted;
        gap = sender_gapless ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= c.cmd;
        cmd_ch.char_code  <= c.char_code;
        cmd_ch.cell_index <= c.cell_index;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predicted = advance_console(c);
        reports_due.push_back(typed ? want : predicted);
        commands_sent++;
    endtask

    task automatic send_fresh(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx);
        console_cmd_t c;
        c.cmd        = cmd;
        c.char_code  = ch;
        c.cell_index = idx;
        send_cmd(c, 1'b0, '0);
    endtask

    task automatic pause_until_drained();
        cmd_ch.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_attribute(input logic [ATTR_W-1:0] attr);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= attr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_attr = attr;
        attrs_loaded++;
    endtask

    // Mostly text lines with random content; the rest reads, line-feed bursts
    // (these scroll once the cursor sits on the last row), clears and noise.
    task automatic run_traffic(input int unsigned budget);
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        int unsigned here;
        int unsigned back;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 4) == 0)
                sender_gapless = !sender_gapless;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170)
                                                  : $urandom_range(0, 30);
                // Trim the last line to what is left of the budget
                if (len > budget - sent)
                    len = budget - sent;
                for (int unsigned k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        ch = CH_TAB;
                    else if (pick < 13)
                        ch = CH_BS;
                    else
                        ch = CHAR_W'($urandom_range(CH_SPACE, CH_DEL));
                    send_fresh(CMD_PUT, ch, IDX_W'($urandom));
                    sent++;
                end
                pick = $urandom_range(0, 9);
                if (pick >= 6 && pick <= 8) begin
                    send_fresh(CMD_PUT, CH_CR, IDX_W'($urandom));
                    sent++;
                end
                if (pick <= 7) begin
                    send_fresh(CMD_PUT, CH_LF, IDX_W'($urandom));
                    sent++;
                end
            end else if (pick < 75) begin
                len = $urandom_range(1, 4);
                for (int unsigned k = 0; k < len; k++) begin
                    // Favor cells just behind the cursor, where text was written
                    here = shadow_row * COLS + shadow_col;
                    back = $urandom_range(1, 90);
                    if ($urandom_range(0, 1) == 0)
                        send_fresh(CMD_READ, CHAR_W'($urandom),
                                   IDX_W'((here > back) ? here - back : 0));
                    else
                        send_fresh(CMD_READ, CHAR_W'($urandom),
                                   IDX_W'($urandom_range(0, CELLS - 1)));
                    sent++;
                end
            end else if (pick < 85) begin
                len = $urandom_range(1, 6);
                for (int unsigned k = 0; k < len; k++) begin
                    send_fresh(CMD_PUT, CH_LF, IDX_W'($urandom));
                    sent++;
                end
            end else if (pick < 97) begin
                // Noise: any opcode, any byte, any index; not counted
                send_fresh(CMD_W'($urandom_range(0, 3)), CHAR_W'($urandom),
                           IDX_W'($urandom));
            end else begin
                send_fresh(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
                sent++;
            end
        end
    endtask

    // Result sink: random stalls, one long hold-off on request
    initial begin
        int unsigned     stall;
        console_report_t want;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                stall = sink_gapless ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            reports_seen++;
            if (reports_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual cursor %0d cell %h",
                         $time, res_ch.cursor_index, res_ch.cell_data);
            end else begin
                want = reports_due.pop_front();
                if (res_ch.cursor_index !== want.cursor_index) begin
                    mismatches++;
                    $display("%0t: cursor_index expected %0d actual %0d",
                             $time, want.cursor_index, res_ch.cursor_index);
                end
                if (res_ch.cell_data !== want.cell_data) begin
                    mismatches++;
                    $display("%0t: cell_data expected %h actual %h",
                             $time, want.cell_data, res_ch.cell_data);
                end
            end
            if ($urandom_range(0, 19) == 0)
                sink_gapless = !sink_gapless;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("%0t: run limit reached with %0d results outstanding",
                     $time, reports_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [ATTR_W-1:0] attr;
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd        = '0;
        cmd_ch.char_code  = '0;
        cmd_ch.cell_index = '0;
        shadow_attr       = ATTR_RESET;
        blank_cells(0, CELLS);
        shadow_col = 0;
        shadow_row = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset screen, out-of-range reads, each byte class, unused opcode
        add_row(CMD_READ,   8'h00,    11'd0,    1'b1, 0,  16'h0F20);
        add_row(CMD_READ,   8'hFF,    11'd1999, 1'b1, 0,  16'h0F20);
        add_row(CMD_READ,   8'h00,    11'd2000, 1'b1, 0,  16'h0000);
        add_row(CMD_READ,   8'h00,    11'd2047, 1'b1, 0,  16'h0000);
        add_row(CMD_PUT,    CH_BS,    11'd0,    1'b1, 0,  16'h0000);
        add_row(CMD_PUT,    8'h41,    11'd2047, 1'b1, 1,  16'h0000);
        add_row(CMD_PUT,    CH_DEL,   11'd0,    1'b1, 2,  16'h0000);
        add_row(CMD_PUT,    CH_SPACE, 11'd0,    1'b1, 3,  16'h0000);
        add_row(CMD_READ,   8'h00,    11'd0,    1'b1, 3,  16'h0F41);
        add_row(CMD_READ,   8'h00,    11'd1,    1'b1, 3,  16'h0F7F);
        add_row(CMD_PUT,    CH_BS,    11'd0,    1'b1, 2,  16'h0000);
        add_row(CMD_PUT,    CH_TAB,   11'd0,    1'b1, 8,  16'h0000);
        add_row(CMD_PUT,    CH_TAB,   11'd0,    1'b1, 16, 16'h0000);
        add_row(CMD_PUT,    CH_CR,    11'd0,    1'b1, 0,  16'h0000);
        add_row(CMD_PUT,    CH_LF,    11'd0,    1'b1, 80, 16'h0000);
        add_row(CMD_PUT,    CH_US,    11'd0,    1'b1, 80, 16'h0000);
        add_row(CMD_PUT,    8'h80,    11'd0,    1'b1, 80, 16'h0000);
        add_row(CMD_PUT,    8'hFF,    11'd0,    1'b1, 80, 16'h0000);
        add_row(CMD_UNUSED, 8'hFF,    11'd5,    1'b1, 80, 16'h0000);
        add_row(CMD_PUT,    8'h7E,    11'd0,    1'b1, 81, 16'h0000);
        add_row(CMD_READ,   8'h00,    11'd80,   1'b1, 81, 16'h0F7E);
        add_row(CMD_PUT,    CH_VT,    11'd0,    1'b1, 81, 16'h0000);
        add_row(CMD_CLEAR,  8'h41,    11'd80,   1'b1, 0,  16'h0000);
        add_row(CMD_READ,   8'h00,    11'd80,   1'b1, 0,  16'h0F20);
        foreach (directed_rows[k])
            send_cmd(directed_rows[k].c, directed_rows[k].typed, directed_rows[k].want);

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            pause_until_drained();
            case (phase)
                0: attr = 8'h00;
                1: attr = 8'hFF;
                default: attr = ATTR_W'($urandom_range(0, 255));
            endcase
            load_attribute(attr);
            // Hold the sink off while the source keeps offering beats
            if (phase == 1)
                hold_off_req = 1'b1;
            run_traffic(ITEMS_PER_PHASE / 2);
            pause_until_drained();
            run_traffic(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands and %0d results under %0d text attributes,",
                 commands_sent, reports_seen, attrs_loaded + 1);
        $display("with %0d scrolls, %0d clears and %0d mismatches.",
                 scrolls_seen, clears_seen, mismatches);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
